@@ hdl/nearest_neighbour_image_scaler_defines.svh @@
// Assertion macros shared by the scaler RTL.
`ifndef NEAREST_NEIGHBOUR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOUR_IMAGE_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnis: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnis: next-cycle check failed");

`endif

@@ hdl/nnis_pkg.sv @@
`default_nettype none

package nnis_pkg;

  localparam int COORD_W    = 12;
  localparam int SRC_SIZE_W = 9;
  localparam int TGT_SIZE_W = 13;
  localparam int PROD_W     = COORD_W + SRC_SIZE_W;
  localparam int QUOT_W     = SRC_SIZE_W;
  localparam int CNT_W      = $clog2(QUOT_W + 1);
  localparam int IN_PIX_W   = 32;
  localparam int OUT_PIX_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TGT_SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [IN_PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [OUT_PIX_W-1:0] pixel_out;
    logic                 out_of_range;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_W-1:0]    a;
    logic [SRC_SIZE_W-1:0] b;
    logic [TGT_SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/nnis_muldiv.sv @@
`default_nettype none

module nnis_muldiv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nnis_pkg::div_req_t req,
  output nnis_pkg::div_rsp_t     rsp
);

  logic [nnis_pkg::COORD_W-1:0]    a_r, a_nxt;
  logic [nnis_pkg::SRC_SIZE_W-1:0] b_r, b_nxt;
  logic [nnis_pkg::PROD_W-1:0]     rem_r, rem_nxt;
  logic [nnis_pkg::PROD_W-1:0]     dsh_r, dsh_nxt;
  logic [nnis_pkg::QUOT_W-1:0]     q_r, q_nxt;
  logic [nnis_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            mul_r, mul_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic                            ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    mul_nxt  = mul_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    priority if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      dsh_nxt  = nnis_pkg::PROD_W'(req.divisor) << (nnis_pkg::QUOT_W - 1);
      q_nxt    = '0;
      cnt_nxt  = nnis_pkg::CNT_W'(nnis_pkg::QUOT_W);
      mul_nxt  = 1'b1;
      busy_nxt = 1'b1;
    end else if (mul_r) begin
      rem_nxt = nnis_pkg::PROD_W'(a_r) * nnis_pkg::PROD_W'(b_r);
      mul_nxt = 1'b0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[nnis_pkg::QUOT_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - nnis_pkg::CNT_W'(1);
      if (cnt_r == nnis_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      mul_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

@@ hdl/nnis_store.sv @@
`default_nettype none

module nnis_store #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/nearest_neighbour_image_scaler.sv @@
// Nearest-neighbor image scaler with a built-in source frame store.
// Input transactions (in_valid / in_stall, payload in_data) carry a mode bit.
// A write transaction stores pixel_in at source (coord_x, coord_y); writes
// outside the configured source size are dropped and produce no output.
// A read transaction names a destination pixel and produces one output
// transaction (out_valid / out_stall, payload out_data) with the source
// pixel at floor(x*source_width/target_width), floor(y*source_height/
// target_height), or zero with out_of_range set when (x, y) is outside the
// target size.
// One shared multiply-then-divide unit computes both source coordinates in
// turn, one quotient bit per cycle, while an in-range read steps through the
// states DIVX, DIVY, READ and LOAD. A write passes through WRITE only, and an
// out-of-range read goes straight to LOAD.
// The block takes no new transaction while an item is in progress.
// When the receiver stalls, the result holds in the output register and
// the next input transaction is still accepted; a further result waits in the
// sequencer until the output register frees.
// Reset sets all sizes to 256 and empties the output; the frame store keeps
// no reset state and must be written before it is read.

`default_nettype none
`include "nearest_neighbour_image_scaler_defines.svh"

module nearest_neighbour_image_scaler #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int PIXEL_BITS        = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire nnis_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output nnis_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [nnis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW     = $clog2(MAX_SOURCE_HEIGHT);

  localparam logic [nnis_pkg::TGT_SIZE_W-1:0] MAXW_L =
    nnis_pkg::TGT_SIZE_W'(MAX_SOURCE_WIDTH);
  localparam logic [nnis_pkg::TGT_SIZE_W-1:0] MAXH_L =
    nnis_pkg::TGT_SIZE_W'(MAX_SOURCE_HEIGHT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_DIVX  = 3'd2;
  localparam logic [2:0] S_DIVY  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [nnis_pkg::SRC_SIZE_W-1:0] sw_r, sw_nxt, sh_r, sh_nxt;
  logic [nnis_pkg::TGT_SIZE_W-1:0] tw_r, tw_nxt, th_r, th_nxt;
  logic [nnis_pkg::SRC_SIZE_W-1:0] sw_c, sh_c;

  logic [2:0]                      state_r, state_nxt;
  logic [nnis_pkg::COORD_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [nnis_pkg::IN_PIX_W-1:0]   pix_r, pix_nxt;
  logic                            oor_r, oor_nxt;
  logic [nnis_pkg::QUOT_W-1:0]     sx_r, sx_nxt, sy_r, sy_nxt;
  logic                            out_valid_r, out_valid_nxt;
  nnis_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                            in_acc;
  logic                            in_oor;
  logic                            load;
  logic                            wr_in_range;
  logic [nnis_pkg::COORD_W-1:0]    ax, ay;
  logic [ADDR_W-1:0]               addr;
  logic                            mem_we, mem_re;
  logic [PIXEL_BITS-1:0]           mem_rdata;
  nnis_pkg::div_req_t              div_req;
  nnis_pkg::div_rsp_t              div_rsp;

  // Effective source size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    priority if (sw_r == '0) begin
      sw_c = nnis_pkg::SRC_SIZE_W'(1);
    end else if (nnis_pkg::TGT_SIZE_W'(sw_r) > MAXW_L) begin
      sw_c = MAXW_L[nnis_pkg::SRC_SIZE_W-1:0];
    end else begin
      sw_c = sw_r;
    end
    priority if (sh_r == '0) begin
      sh_c = nnis_pkg::SRC_SIZE_W'(1);
    end else if (nnis_pkg::TGT_SIZE_W'(sh_r) > MAXH_L) begin
      sh_c = MAXH_L[nnis_pkg::SRC_SIZE_W-1:0];
    end else begin
      sh_c = sh_r;
    end
  end

  always_comb begin
    sw_nxt = sw_r;
    sh_nxt = sh_r;
    tw_nxt = tw_r;
    th_nxt = th_r;
    if (cfg_we) begin
      unique case (cfg_index)
        nnis_pkg::REG_SOURCE_WIDTH:  sw_nxt = cfg_wdata[nnis_pkg::SRC_SIZE_W-1:0];
        nnis_pkg::REG_SOURCE_HEIGHT: sh_nxt = cfg_wdata[nnis_pkg::SRC_SIZE_W-1:0];
        nnis_pkg::REG_TARGET_WIDTH:  tw_nxt = cfg_wdata;
        nnis_pkg::REG_TARGET_HEIGHT: th_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_oor   = (nnis_pkg::TGT_SIZE_W'(in_data.coord_x) >= tw_r) ||
                    (nnis_pkg::TGT_SIZE_W'(in_data.coord_y) >= th_r);

  assign wr_in_range = (x_r < nnis_pkg::COORD_W'(sw_c)) &&
                       (y_r < nnis_pkg::COORD_W'(sh_c));

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    pix_nxt        = pix_r;
    oor_nxt        = oor_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load           = 1'b0;
    div_req.start   = 1'b0;
    div_req.a       = y_r;
    div_req.b       = sh_c;
    div_req.divisor = th_r;
    unique case (state_r)
      S_IDLE: begin
        div_req.a       = in_data.coord_x;
        div_req.b       = sw_c;
        div_req.divisor = tw_r;
        if (in_acc) begin
          x_nxt   = in_data.coord_x;
          y_nxt   = in_data.coord_y;
          pix_nxt = in_data.pixel_in;
          oor_nxt = in_oor;
          if (in_data.mode == nnis_pkg::MODE_WRITE) begin
            state_nxt = S_WRITE;
          end else if (in_oor) begin
            state_nxt = S_LOAD;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIVX;
          end
        end
      end
      S_WRITE: begin
        mem_we    = wr_in_range;
        state_nxt = S_IDLE;
      end
      S_DIVX: begin
        if (div_rsp.done) begin
          sx_nxt        = div_rsp.quot;
          div_req.start = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_rsp.done) begin
          sy_nxt    = div_rsp.quot;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_of_range = oor_r;
      out_data_nxt.pixel_out  = oor_r ? '0 : nnis_pkg::OUT_PIX_W'(mem_rdata);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign ax   = (state_r == S_WRITE) ? x_r : nnis_pkg::COORD_W'(sx_r);
  assign ay   = (state_r == S_WRITE) ? y_r : nnis_pkg::COORD_W'(sy_r);
  assign addr = ADDR_W'(ADDR_W'(ay[YW-1:0]) * ADDR_W'(MAX_SOURCE_WIDTH)) +
                ADDR_W'(ax[XW-1:0]);

  nnis_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nnis_store #(
    .DEPTH  (DEPTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr),
    .wdata (PIXEL_BITS'(pix_r)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    pix_r      <= pix_nxt;
    oor_r      <= oor_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sw_r        <= nnis_pkg::SRC_SIZE_W'(256);
      sh_r        <= nnis_pkg::SRC_SIZE_W'(256);
      tw_r        <= nnis_pkg::TGT_SIZE_W'(256);
      th_r        <= nnis_pkg::TGT_SIZE_W'(256);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sw_r        <= sw_nxt;
      sh_r        <= sh_nxt;
      tw_r        <= tw_nxt;
      th_r        <= th_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NNIS_ASSERT_SAME(a_done_in_div, div_rsp.done, (state_r == S_DIVX) || (state_r == S_DIVY))
  `NNIS_ASSERT_SAME(a_load_free, load, !out_valid_r || !out_stall)
  `NNIS_ASSERT_SAME(a_oor_zero, out_valid && out_data.out_of_range, out_data.pixel_out == '0)
  `NNIS_ASSERT_NEXT(a_write_path, in_acc && (in_data.mode == nnis_pkg::MODE_WRITE), state_r == S_WRITE)

endmodule

`default_nettype wire

@@ tb/nearest_neighbour_image_scaler_tb.sv @@
`default_nettype none

module nearest_neighbour_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SRC_W     = 256;
  localparam int MAX_SRC_H     = 256;
  localparam int SETTLE_CYCLES = 40;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  nnis_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  nnis_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [nnis_pkg::IN_PIX_W-1:0]   frame_mem    [MAX_SRC_W*MAX_SRC_H];
  bit                              frame_filled [MAX_SRC_W*MAX_SRC_H];
  logic [nnis_pkg::SRC_SIZE_W-1:0] src_w_reg = 9'd256;
  logic [nnis_pkg::SRC_SIZE_W-1:0] src_h_reg = 9'd256;
  logic [nnis_pkg::TGT_SIZE_W-1:0] tgt_w_reg = 13'd256;
  logic [nnis_pkg::TGT_SIZE_W-1:0] tgt_h_reg = 13'd256;

  nnis_pkg::out_item_t             expected_pixels [$];
  nnis_pkg::out_item_t             oldest_pixel;
  int                              error_count = 0;
  bit                              steady      = 1'b0;
  bit                              out_seen    = 1'b0;
  bit                              out_fire    = 1'b0;
  int                              stall_left  = 0;

  nearest_neighbour_image_scaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // The stall count only runs down while a result is offered, so stalls land
  // on fresh results as well as on ones already waiting.
  always @(posedge clk) begin
    if (out_fire) begin
      stall_left = steady ? 0 : $urandom_range(0, 7);
    end else if (out_seen && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  always @(negedge clk) begin
    out_seen = rst_n && out_valid;
    out_fire = out_seen && !out_stall;
    if (out_fire) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result transaction: pixel_out %h, out_of_range %b",
               out_data.pixel_out, out_data.out_of_range);
        error_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_data.pixel_out !== oldest_pixel.pixel_out) begin
          $error("pixel_out mismatch: expected %h, actual %h",
                 oldest_pixel.pixel_out, out_data.pixel_out);
          error_count++;
        end
        if (out_data.out_of_range !== oldest_pixel.out_of_range) begin
          $error("out_of_range mismatch: expected %b, actual %b",
                 oldest_pixel.out_of_range, out_data.out_of_range);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_size(logic [nnis_pkg::SRC_SIZE_W-1:0] v,
                                           int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic bit outside_target(logic [nnis_pkg::COORD_W-1:0] x,
                                        logic [nnis_pkg::COORD_W-1:0] y);
    return (x >= tgt_w_reg) || (y >= tgt_h_reg);
  endfunction

  function automatic int unsigned mapped_addr(logic [nnis_pkg::COORD_W-1:0] x,
                                              logic [nnis_pkg::COORD_W-1:0] y);
    int unsigned xu, yu, sx, sy;
    xu = x;
    yu = y;
    sx = xu * eff_size(src_w_reg, MAX_SRC_W) / tgt_w_reg;
    sy = yu * eff_size(src_h_reg, MAX_SRC_H) / tgt_h_reg;
    return sy * MAX_SRC_W + sx;
  endfunction

  function automatic nnis_pkg::in_item_t pack_item(logic mode,
                                                   logic [nnis_pkg::COORD_W-1:0] x,
                                                   logic [nnis_pkg::COORD_W-1:0] y,
                                                   logic [nnis_pkg::IN_PIX_W-1:0] pix);
    nnis_pkg::in_item_t it;
    it.mode     = mode;
    it.coord_x  = x;
    it.coord_y  = y;
    it.pixel_in = pix;
    return it;
  endfunction

  function automatic logic [nnis_pkg::COORD_W-1:0] pick_coord(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return nnis_pkg::COORD_W'(span - 1);
    return nnis_pkg::COORD_W'($urandom_range(0, span - 1));
  endfunction

  task automatic scale_predict(nnis_pkg::in_item_t it);
    nnis_pkg::out_item_t res;
    int unsigned         addr;
    if (it.mode == nnis_pkg::MODE_WRITE) begin
      if (it.coord_x < eff_size(src_w_reg, MAX_SRC_W) &&
          it.coord_y < eff_size(src_h_reg, MAX_SRC_H)) begin
        addr = it.coord_y * MAX_SRC_W + it.coord_x;
        frame_mem[addr]    = it.pixel_in;
        frame_filled[addr] = 1'b1;
      end
    end else begin
      if (outside_target(it.coord_x, it.coord_y)) begin
        res.pixel_out    = '0;
        res.out_of_range = 1'b1;
      end else begin
        res.pixel_out    = frame_mem[mapped_addr(it.coord_x, it.coord_y)];
        res.out_of_range = 1'b0;
      end
      expected_pixels.push_back(res);
    end
  endtask

  task automatic send_item(nnis_pkg::in_item_t it);
    int gap;
    bit accepted;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scale_predict(it);
    in_valid <= 1'b1;
    in_data  <= it;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic write_pixel(logic [nnis_pkg::COORD_W-1:0] x, logic [nnis_pkg::COORD_W-1:0] y,
                             logic [nnis_pkg::IN_PIX_W-1:0] pix);
    send_item(pack_item(nnis_pkg::MODE_WRITE, x, y, pix));
  endtask

  // A read whose source pixel was never stored first gets that pixel written.
  task automatic read_pixel(logic [nnis_pkg::COORD_W-1:0] x, logic [nnis_pkg::COORD_W-1:0] y);
    int unsigned addr;
    if (!outside_target(x, y)) begin
      addr = mapped_addr(x, y);
      if (!frame_filled[addr]) begin
        write_pixel(nnis_pkg::COORD_W'(addr % MAX_SRC_W), nnis_pkg::COORD_W'(addr / MAX_SRC_W),
                    $urandom());
      end
    end
    send_item(pack_item(nnis_pkg::MODE_READ, x, y, $urandom()));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_sizes(logic [nnis_pkg::CFG_DATA_W-1:0] sw,
                             logic [nnis_pkg::CFG_DATA_W-1:0] sh,
                             logic [nnis_pkg::CFG_DATA_W-1:0] tw,
                             logic [nnis_pkg::CFG_DATA_W-1:0] th);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= nnis_pkg::REG_SOURCE_WIDTH;
    cfg_wdata <= sw;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_SOURCE_HEIGHT;
    cfg_wdata <= sh;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_TARGET_WIDTH;
    cfg_wdata <= tw;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_TARGET_HEIGHT;
    cfg_wdata <= th;
    @(posedge clk);
    cfg_we    <= 1'b0;
    src_w_reg = sw[nnis_pkg::SRC_SIZE_W-1:0];
    src_h_reg = sh[nnis_pkg::SRC_SIZE_W-1:0];
    tgt_w_reg = tw;
    tgt_h_reg = th;
  endtask

  task automatic random_traffic(int count);
    int unsigned sw, sh, span_x, span_y, kind;
    sw     = eff_size(src_w_reg, MAX_SRC_W);
    sh     = eff_size(src_h_reg, MAX_SRC_H);
    span_x = (tgt_w_reg > 4096) ? 4096 : tgt_w_reg;
    span_y = (tgt_h_reg > 4096) ? 4096 : tgt_h_reg;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        write_pixel(pick_coord(sw), pick_coord(sh), $urandom());
      end else if (kind < 40) begin
        write_pixel(pick_coord(4096), pick_coord(4096), $urandom());
      end else if (kind < 88 && span_x != 0 && span_y != 0) begin
        read_pixel(pick_coord(span_x), pick_coord(span_y));
      end else begin
        read_pixel(pick_coord(4096), pick_coord(4096));
      end
    end
  endtask

  // Reset sizes give a one-to-one mapping, so corners read back directly.
  task automatic test_reset_defaults();
    write_pixel(12'd0, 12'd0, 32'h0000_0000);
    write_pixel(12'd255, 12'd255, 32'hFFFF_FFFF);
    write_pixel(12'd255, 12'd0, 32'hAAAA_AAAA);
    write_pixel(12'd0, 12'd255, 32'h5555_5555);
    write_pixel(12'd0, 12'd1, 32'h1234_5678);
    write_pixel(12'd256, 12'd0, 32'hDEAD_BEEF);
    write_pixel(12'd0, 12'd256, 32'hDEAD_BEEF);
    write_pixel(12'd4095, 12'd4095, 32'hDEAD_BEEF);
    read_pixel(12'd0, 12'd0);
    read_pixel(12'd255, 12'd255);
    read_pixel(12'd255, 12'd0);
    read_pixel(12'd0, 12'd255);
    read_pixel(12'd0, 12'd1);
    read_pixel(12'd256, 12'd0);
    read_pixel(12'd0, 12'd256);
    read_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_size_extremes();
    apply_sizes(13'd1, 13'd1, 13'd1, 13'd1);
    random_traffic(30);
    apply_sizes(13'd1, 13'd1, 13'd4096, 13'd4096);
    random_traffic(40);
    apply_sizes(13'd256, 13'd256, 13'd1, 13'd1);
    random_traffic(30);
    apply_sizes(13'd256, 13'd256, 13'd4096, 13'd4096);
    random_traffic(40);
    apply_sizes(13'd0, 13'd0, 13'd256, 13'd256);
    random_traffic(30);
    apply_sizes(13'd300, 13'd511, 13'd200, 13'd3000);
    random_traffic(40);
    apply_sizes(13'd16, 13'd16, 13'd0, 13'd0);
    random_traffic(30);
    apply_sizes(13'd256, 13'd1, 13'd8191, 13'd8191);
    random_traffic(40);
    apply_sizes(13'd7, 13'd256, 13'd4096, 13'd1);
    random_traffic(30);
  endtask

  task automatic test_back_to_back();
    apply_sizes(13'd9, 13'd5, 13'd33, 13'd17);
    steady = 1'b1;
    random_traffic(100);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random_scaling();
    bit big;
    repeat (10) begin
      big = ($urandom_range(0, 4) == 0);
      if (big) begin
        apply_sizes(nnis_pkg::CFG_DATA_W'($urandom_range(1, 256)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 256)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 4096)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 4096)));
      end else begin
        apply_sizes(nnis_pkg::CFG_DATA_W'($urandom_range(1, 16)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 16)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 64)),
                    nnis_pkg::CFG_DATA_W'($urandom_range(1, 64)));
      end
      random_traffic(70);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_size_extremes();
    test_back_to_back();
    test_random_scaling();
    drain();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
